// ===== hdl/rrp_pkg.sv =====
// Shared types and constants for the rangefinder reply parser.
`default_nettype none

package rrp_pkg;

	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_OVERRUN = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		EV_PROGRESS  = 4'd0,
		EV_HDR       = 4'd1,
		EV_OPEN_OK   = 4'd2,
		EV_OPEN_BAD  = 4'd3,
		EV_SCALE_OK  = 4'd4,
		EV_SCALE_BAD = 4'd5,
		EV_ERRREP    = 4'd6,
		EV_CSUM_BAD  = 4'd7,
		EV_GOOD      = 4'd8,
		EV_IGNORED   = 4'd9,
		EV_OVERRUN   = 4'd10,
		EV_RELEASED  = 4'd11
	} event_t;

	localparam logic [1:0] PH_OPEN  = 2'd0;
	localparam logic [1:0] PH_SCALE = 2'd1;
	localparam logic [1:0] PH_MEAS  = 2'd2;

	localparam logic [3:0] FRAME_LEN   = 4'd11;
	localparam logic [3:0] POS_BODY    = 4'd3;
	localparam logic [3:0] POS_ERR     = 4'd8;
	localparam logic [3:0] POS_CSUM    = 4'd10;
	localparam int         BODY_BYTES  = 7;

	localparam logic [7:0] OPEN_HDR0  = 8'h80;
	localparam logic [7:0] OPEN_HDR1  = 8'h06;
	localparam logic [7:0] OPEN_HDR2  = 8'h85;
	localparam logic [7:0] OPEN_HDR3  = 8'h01;
	localparam logic [7:0] SCALE_HDR0 = 8'hFA;
	localparam logic [7:0] SCALE_HDR1 = 8'h04;
	localparam logic [7:0] SCALE_HDR2 = 8'h89;
	localparam logic [7:0] SCALE_HDR3 = 8'h79;
	localparam logic [7:0] MEAS_HDR0  = 8'h80;
	localparam logic [7:0] MEAS_HDR1  = 8'h06;
	localparam logic [7:0] MEAS_HDR2  = 8'h82;
	localparam logic [7:0] CHAR_E     = 8'h45;
	localparam logic [7:0] CHAR_R     = 8'h52;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [1:0]  phase;
		logic [3:0]  byte_count;
		logic        frame_ready;
		logic [55:0] payload;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/rangefinder_reply_parser.sv =====
// Rangefinder reply parser: byte-wise header, error and checksum checks.
// Each item is first held in the input register; its result is loaded into the
// result register when the state advances, which waits while the result output is stalled.
// Throughput: one item per cycle while the result output is not stalled, as the state
// (phase, count, running checksum, frame bytes) updates for every accepted item.
// Reset: phase awaits the open reply, count, checksum and held flag clear.
`default_nettype none

module rangefinder_reply_parser
	import rrp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output      logic    item_stall,
	input  wire item_t   item,
	output      logic    result_valid,
	input  wire logic    result_stall,
	output      result_t result
);

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;

	logic [1:0]  phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic        ready_q, ready_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  body_q [BODY_BYTES];
	logic [7:0]  body_d [BODY_BYTES];
	logic        body_we;
	logic [2:0]  body_idx;

	event_t      ev;
	logic [7:0]  b;
	logic [7:0]  expect_byte;
	logic [7:0]  last_byte;
	logic [1:0]  pos2;
	logic        is_err;
	logic [55:0] payload_d;
	logic [7:0]  csum;

	assign advance    = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	assign b        = item_s1.rx_byte;
	assign pos2     = count_q[1:0];
	assign is_err   = (body_q[0] == CHAR_E) && (body_q[1] == CHAR_R) && (body_q[2] == CHAR_R);
	assign csum     = 8'(8'd0 - sum_q);
	assign body_idx = 3'(count_q - POS_BODY);

	always_comb begin
		expect_byte = 8'h00;
		last_byte   = 8'h00;
		if (phase_q == PH_OPEN) begin
			last_byte = OPEN_HDR3;
			unique case (pos2)
				2'd0:    expect_byte = OPEN_HDR0;
				2'd1:    expect_byte = OPEN_HDR1;
				2'd2:    expect_byte = OPEN_HDR2;
				default: expect_byte = OPEN_HDR3;
			endcase
		end else if (phase_q == PH_SCALE) begin
			last_byte = SCALE_HDR3;
			unique case (pos2)
				2'd0:    expect_byte = SCALE_HDR0;
				2'd1:    expect_byte = SCALE_HDR1;
				2'd2:    expect_byte = SCALE_HDR2;
				default: expect_byte = SCALE_HDR3;
			endcase
		end else begin
			unique case (pos2)
				2'd0:    expect_byte = MEAS_HDR0;
				2'd1:    expect_byte = MEAS_HDR1;
				default: expect_byte = MEAS_HDR2;
			endcase
		end
	end

	always_comb begin
		ev      = EV_IGNORED;
		phase_d = phase_q;
		count_d = count_q;
		ready_d = ready_q;
		sum_d   = sum_q;
		body_we = 1'b0;
		unique case (item_s1.command)
			CMD_BYTE: begin
				if (!ready_q) begin
					unique case (phase_q)
						PH_OPEN, PH_SCALE: begin
							if (pos2 != 2'd3) begin
								if (b != expect_byte) begin
									count_d = 4'd0;
									sum_d   = 8'd0;
									ev      = EV_HDR;
								end else begin
									count_d = {2'b00, pos2} + 4'd1;
									ev      = EV_PROGRESS;
								end
							end else begin
								count_d = 4'd0;
								sum_d   = 8'd0;
								if (b != last_byte) begin
									ev = (phase_q == PH_OPEN) ? EV_OPEN_BAD : EV_SCALE_BAD;
								end else begin
									phase_d = phase_q + 2'd1;
									ev = (phase_q == PH_OPEN) ? EV_OPEN_OK : EV_SCALE_OK;
								end
							end
						end
						PH_MEAS: begin
							if (count_q >= FRAME_LEN) begin
								ev = EV_IGNORED;
							end else if (count_q < POS_BODY && b != expect_byte) begin
								count_d = 4'd0;
								sum_d   = 8'd0;
								ev      = EV_HDR;
							end else if (count_q < POS_CSUM) begin
								body_we = (count_q >= POS_BODY);
								if (count_q == POS_ERR && is_err) begin
									count_d = 4'd0;
									sum_d   = 8'd0;
									ev      = EV_ERRREP;
								end else begin
									sum_d   = (count_q == 4'd0) ? b : 8'(sum_q + b);
									count_d = count_q + 4'd1;
									ev      = EV_PROGRESS;
								end
							end else if (csum != b) begin
								count_d = 4'd0;
								sum_d   = 8'd0;
								ev      = EV_CSUM_BAD;
							end else begin
								count_d = FRAME_LEN;
								ready_d = 1'b1;
								ev      = EV_GOOD;
							end
						end
						default: ev = EV_IGNORED;
					endcase
				end
			end
			CMD_OVERRUN: begin
				count_d = 4'd0;
				sum_d   = 8'd0;
				ready_d = 1'b0;
				ev      = EV_OVERRUN;
			end
			CMD_RELEASE: begin
				if (ready_q) begin
					ready_d = 1'b0;
					count_d = 4'd0;
					sum_d   = 8'd0;
					ev      = EV_RELEASED;
				end
			end
			default: ev = EV_IGNORED;
		endcase
	end

	always_comb begin
		for (int i = 0; i < BODY_BYTES; i++) begin
			body_d[i] = body_q[i];
		end
		if (body_we) begin
			body_d[body_idx] = b;
		end
	end

	always_comb begin
		payload_d = '0;
		if (ev == EV_GOOD) begin
			payload_d = {body_q[0], body_q[1], body_q[2], body_q[3],
				body_q[4], body_q[5], body_q[6]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OPEN;
			count_q      <= 4'd0;
			ready_q      <= 1'b0;
			sum_q        <= 8'd0;
			result_valid <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				count_q <= count_d;
				ready_q <= ready_d;
				sum_q   <= sum_d;
			end
			if (advance) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < BODY_BYTES; i++) begin
				body_q[i] <= body_d[i];
			end
			result.event_res   <= ev;
			result.phase       <= phase_d;
			result.byte_count  <= count_d;
			result.frame_ready <= ready_d;
			result.payload     <= payload_d;
		end
	end

endmodule

`default_nettype wire
